@@ rtl/core/sgvi_pkg.sv @@
// ----------------------------------------------------------------------------
// sgvi_pkg
// Shared command codes, field widths and control types for the staggered
// grid velocity block.
// ----------------------------------------------------------------------------
package sgvi_pkg;

    // Command codes carried on the input stream
    localparam logic [2:0] CMD_WR_U   = 3'd0;
    localparam logic [2:0] CMD_WR_V   = 3'd1;
    localparam logic [2:0] CMD_WR_W   = 3'd2;
    localparam logic [2:0] CMD_VERTEX = 3'd3;
    localparam logic [2:0] CMD_CELL   = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] REG_CELLS_X = 2'd0;
    localparam logic [1:0] REG_CELLS_Y = 2'd1;
    localparam logic [1:0] REG_CELLS_Z = 2'd2;

    // Fixed field widths
    localparam int COORD_W = 5;
    localparam int VAL_W   = 16;

    // Averaging control for one axis: which slots count and the divide shift
    typedef struct packed {
        logic [3:0] mask;
        logic [1:0] shift;
    } t_avg_ctl;

endpackage

@@ rtl/core/sgvi_face_store.sv @@
// ----------------------------------------------------------------------------
// sgvi_face_store
// One face-velocity store split into eight banks by coordinate parity, so a
// vertex query (four faces) or a cell query (two faces) reads its faces together.
// ----------------------------------------------------------------------------
module sgvi_face_store #(
    parameter int CW = 5,
    parameter int TW = 4,
    parameter int SB = 16
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [CW-1:0] i_wr_lng,
    input  logic [TW-1:0] i_wr_a,
    input  logic [TW-1:0] i_wr_b,
    input  logic [SB-1:0] i_wr_data,
    input  logic          i_rd_en,
    input  logic          i_rd_cell,
    input  logic [CW-1:0] i_rd_lng,
    input  logic [TW-1:0] i_rd_a,
    input  logic [TW-1:0] i_rd_b,
    output logic [SB-1:0] o_slot [4]
);
    localparam int AW = (CW - 1) + 2 * (TW - 1);
    localparam int DEPTH = 1 << AW;

    logic [SB-1:0] r_q [8];
    logic          r_cell;
    logic          r_l0;
    logic          r_a0;
    logic          r_b0;

    // Bank memories with per-bank read address
    for (genvar k = 0; k < 8; k++) begin : g_bank
        localparam logic [2:0] KB = 3'(k);
        logic [SB-1:0] mem [DEPTH];
        logic [CW-1:0] la;
        logic [TW-1:0] aa;
        logic [TW-1:0] bb;
        logic [AW-1:0] raddr;
        logic [AW-1:0] waddr;
        logic          wsel;

        // Vertex reads step back in the transverse axes, cell reads step
        // forward along the staggered axis.
        always_comb begin
            if (i_rd_cell) begin
                la = (KB[2] == i_rd_lng[0]) ? i_rd_lng : i_rd_lng + 1'b1;
                aa = i_rd_a;
                bb = i_rd_b;
            end else begin
                la = i_rd_lng;
                aa = (KB[1] == i_rd_a[0]) ? i_rd_a : i_rd_a - 1'b1;
                bb = (KB[0] == i_rd_b[0]) ? i_rd_b : i_rd_b - 1'b1;
            end
            raddr = {la[CW-1:1], aa[TW-1:1], bb[TW-1:1]};
            waddr = {i_wr_lng[CW-1:1], i_wr_a[TW-1:1], i_wr_b[TW-1:1]};
            wsel  = i_wr_en && ({i_wr_lng[0], i_wr_a[0], i_wr_b[0]} == KB);
        end

        always_ff @(posedge i_clk) begin
            if (wsel) begin
                mem[waddr] <= i_wr_data;
            end
            if (i_rd_en) begin
                r_q[k] <= mem[raddr];
            end
        end
    end

    // Remember the parities so the bank outputs can be put in slot order
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_cell <= i_rd_cell;
            r_l0   <= i_rd_lng[0];
            r_a0   <= i_rd_a[0];
            r_b0   <= i_rd_b[0];
        end
    end

    // Slot order: vertex slot {ia,ib} with 0 meaning the lower neighbour;
    // cell slots 0 and 1 are the near and far faces.
    always_comb begin
        logic [2:0] k;
        for (int s = 0; s < 4; s++) begin
            if (r_cell) begin
                k = {r_l0 ^ s[0], r_a0, r_b0};
            end else begin
                k = {r_l0, s[1] ? r_a0 : ~r_a0, s[0] ? r_b0 : ~r_b0};
            end
            o_slot[s] = r_q[k];
        end
    end

endmodule

@@ rtl/core/sgvi_avg.sv @@
// ----------------------------------------------------------------------------
// sgvi_avg
// Sums the selected face samples of one axis and divides by the face count
// with an arithmetic right shift.
// ----------------------------------------------------------------------------
module sgvi_avg #(
    parameter int SB = 16
) (
    input  logic [SB-1:0]          i_slot [4],
    input  sgvi_pkg::t_avg_ctl     i_ctl,
    output logic [sgvi_pkg::VAL_W-1:0] o_vel
);
    import sgvi_pkg::*;

    logic signed [SB+1:0]  sum;
    logic signed [SB+17:0] wide;

    // Masked sum of up to four samples, then floor division by 1, 2 or 4
    always_comb begin
        sum = '0;
        for (int s = 0; s < 4; s++) begin
            if (i_ctl.mask[s]) begin
                sum = sum + $signed({{2{i_slot[s][SB-1]}}, i_slot[s]});
            end
        end
        wide  = $signed({{16{sum[SB+1]}}, sum}) >>> i_ctl.shift;
        o_vel = wide[VAL_W-1:0];
    end

endmodule

@@ rtl/core/staggered_grid_velocity_interp_top.sv @@
// ----------------------------------------------------------------------------
// staggered_grid_velocity_interp_top
// MAC grid face-velocity store with vertex and cell-centre averaging.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle unless stalled and answers
// each query through the read stage and output register; face writes give no
// result. Each of the three face stores is split into eight parity banks, so
// the four faces of a vertex or the two faces of a cell are read together from
// distinct banks. A write is visible to a query accepted in the next cycle.
// Output is held in a register, so while a result waits the block still takes
// writes and one more query; input stalls only when that query is also waiting.
module staggered_grid_velocity_interp_top #(
    parameter int MAX_CELLS   = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [4:0] coord_x, [9:5] coord_y, [14:10] coord_z, [30:15] face_value
    input  logic [31:0] s_axis_tdata,
    // [2:0] command
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [15:0] vel_x, [31:16] vel_y, [47:32] vel_z
    output logic [47:0] m_axis_tdata,
    // [0] status
    output logic        m_axis_tuser
);
    import sgvi_pkg::*;

    localparam int CW = $clog2(MAX_CELLS + 1);
    localparam int TW = ($clog2(MAX_CELLS) < 2) ? 2 : $clog2(MAX_CELLS);
    localparam int SB = SAMPLE_BITS;
    localparam logic [6:0] MAXC = 7'(MAX_CELLS);

    logic [4:0] r_cells [3];
    logic [6:0] eff [3];
    logic [6:0] crd [3];
    logic [7:0] crd8 [3];

    logic         r_s1_valid;
    logic         r_s1_status;
    t_avg_ctl     r_s1_ctl [3];
    t_avg_ctl     n_ctl [3];
    logic         r_out_valid;
    logic         r_out_status;
    logic [15:0]  r_out_vel [3];
    logic [15:0]  vel [3];

    logic         acc;
    logic         adv;
    logic         is_vtx;
    logic         is_cell;
    logic         is_query;
    logic         oor;
    logic [2:0]   cmd;
    logic [15:0]  fval;
    logic [31:0]  fv32;

    assign o_cfg_ready = 1'b1;
    assign cmd  = s_axis_tuser;
    assign fval = s_axis_tdata[30:15];
    assign fv32 = {16'b0, fval};

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cells[0] <= 5'd16;
            r_cells[1] <= 5'd16;
            r_cells[2] <= 5'd16;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CELLS_X: r_cells[0] <= i_cfg_data;
                REG_CELLS_Y: r_cells[1] <= i_cfg_data;
                REG_CELLS_Z: r_cells[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective cell counts, clamped to 1..MAX_CELLS, and coordinates
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_cells[i] == 5'd0) begin
                eff[i] = 7'd1;
            end else if ({2'b0, r_cells[i]} > MAXC) begin
                eff[i] = MAXC;
            end else begin
                eff[i] = {2'b0, r_cells[i]};
            end
            crd[i]  = {2'b0, s_axis_tdata[5*i +: 5]};
            crd8[i] = {1'b0, crd[i]};
        end
    end

    // Flow control: output register frees the pipeline
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_s1_valid || adv;
    assign acc           = s_axis_tvalid && s_axis_tready;
    assign is_vtx        = (cmd == CMD_VERTEX);
    assign is_cell       = (cmd == CMD_CELL);
    assign is_query      = is_vtx || is_cell;
    assign oor = is_vtx ? (crd[0] > eff[0] || crd[1] > eff[1] || crd[2] > eff[2])
                        : (crd[0] >= eff[0] || crd[1] >= eff[1] || crd[2] >= eff[2]);

    // Per-axis store access and averaging
    for (genvar ax = 0; ax < 3; ax++) begin : g_axis
        localparam int AI = (ax == 0) ? 1 : 0;
        localparam int BI = (ax == 2) ? 1 : 2;
        logic          wr_ok;
        logic          ina;
        logic          inb;
        logic [SB-1:0] slot [4];

        // Face bounds for writes: staggered axis may reach the cell count
        assign wr_ok = (crd[ax] <= eff[ax]) && (crd[AI] < eff[AI]) && (crd[BI] < eff[BI]);
        assign ina   = (crd[AI] != 7'd0) && (crd[AI] < eff[AI]);
        assign inb   = (crd[BI] != 7'd0) && (crd[BI] < eff[BI]);

        always_comb begin
            if (is_cell) begin
                n_ctl[ax].mask  = 4'b0011;
                n_ctl[ax].shift = 2'd1;
            end else begin
                for (int s = 0; s < 4; s++) begin
                    n_ctl[ax].mask[s] = (s[1] ? (crd[AI] < eff[AI]) : (crd[AI] != 7'd0))
                                     && (s[0] ? (crd[BI] < eff[BI]) : (crd[BI] != 7'd0));
                end
                n_ctl[ax].shift = {1'b0, ina} + {1'b0, inb};
            end
        end

        sgvi_face_store #(.CW(CW), .TW(TW), .SB(SB)) u_store (
            .i_clk     (i_clk),
            .i_wr_en   (acc && (cmd == 3'(ax)) && wr_ok),
            .i_wr_lng  (crd8[ax][CW-1:0]),
            .i_wr_a    (crd8[AI][TW-1:0]),
            .i_wr_b    (crd8[BI][TW-1:0]),
            .i_wr_data (fv32[SB-1:0]),
            .i_rd_en   (acc && is_query),
            .i_rd_cell (is_cell),
            .i_rd_lng  (crd8[ax][CW-1:0]),
            .i_rd_a    (crd8[AI][TW-1:0]),
            .i_rd_b    (crd8[BI][TW-1:0]),
            .o_slot    (slot)
        );

        sgvi_avg #(.SB(SB)) u_avg (
            .i_slot (slot),
            .i_ctl  (r_s1_ctl[ax]),
            .o_vel  (vel[ax])
        );
    end

    // Read stage: query bookkeeping alongside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= acc && is_query;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && is_query) begin
            r_s1_status <= oor;
            r_s1_ctl    <= n_ctl;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_status <= r_s1_status;
            for (int i = 0; i < 3; i++) begin
                r_out_vel[i] <= r_s1_status ? 16'd0 : vel[i];
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = {r_out_vel[2], r_out_vel[1], r_out_vel[0]};

    // Checks on the pipeline
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 48'd0)
        else $error("out-of-range result carries non-zero velocity");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted while read stage is blocked");

    a_query_tracked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_VERTEX ||
        s_axis_tuser == CMD_CELL) |=> r_s1_valid)
        else $error("accepted query lost in read stage");

endmodule
